// ===== design/iasel_pkg.sv =====
// ----------------------------------------------------------------------------
// iasel_pkg
// Shared constants and types for the interval activity selector.
// ----------------------------------------------------------------------------
`default_nettype none

package iasel_pkg;

    localparam int MAX_ACTIVITIES = 64;
    localparam int TIME_BITS      = 16;
    localparam int TAG_BITS       = 8;
    localparam int CNT_BITS       = $clog2(MAX_ACTIVITIES + 1);

    typedef struct packed {
        logic                 sel;
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] finish;
    } entry_t;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_ROTATE = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t  mode;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/interval_activity_selector_core.sv =====
// ----------------------------------------------------------------------------
// interval_activity_selector_core
// Greedy activity selection: insertion-sorting cell chain, then a marking
// scan and an emitting scan through the head cell.
// ----------------------------------------------------------------------------
// a set of n items loads at one item per cycle into the sorting chain while
// in the load state; after the closing item come a marking scan over the n
// items, then an emit scan that waits on any output stall; results are registered
// no new set is accepted until both serial head scans of the chain are done
// reset clears fill count, counters, flags and output valid; cell contents
// are not reset and need no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module interval_activity_selector_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [iasel_pkg::TAG_BITS-1:0]    tag,
    input  wire logic [iasel_pkg::TIME_BITS-1:0]   start_time,
    input  wire logic [iasel_pkg::TIME_BITS-1:0]   finish_time,
    input  wire logic                              last_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [iasel_pkg::TAG_BITS-1:0]         tag_res,
    output logic [iasel_pkg::TIME_BITS-1:0]        start_time_res,
    output logic [iasel_pkg::TIME_BITS-1:0]        finish_time_res,
    output logic                                   last_result,
    output logic [iasel_pkg::CNT_BITS-1:0]         selected_count,
    output logic                                   overflow
);
    import iasel_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_MARK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                state_reg,   state_next;
    logic [CNT_BITS-1:0]   fill_reg,    fill_next;
    logic [CNT_BITS-1:0]   step_reg,    step_next;
    logic [CNT_BITS-1:0]   taken_reg,   taken_next;
    logic [CNT_BITS-1:0]   emitted_reg, emitted_next;
    logic [TIME_BITS-1:0]  ltf_reg,     ltf_next;
    logic                  dropped_reg, dropped_next;
    logic                  out_valid_reg, out_valid_next;

    logic [TAG_BITS-1:0]   tag_reg,     tag_next;
    logic [TIME_BITS-1:0]  start_reg,   start_next;
    logic [TIME_BITS-1:0]  finish_reg,  finish_next;
    logic                  last_reg,    last_next;
    logic [CNT_BITS-1:0]   count_reg,   count_next;
    logic                  ovf_reg,     ovf_next;

    cell_ctrl_t            ctrl;
    entry_t                head;
    entry_t                wrap_entry;
    logic                  take;
    logic                  in_fire;
    logic                  slot_free;
    logic                  step_end;

    iasel_chain u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .fill       (fill_reg),
        .wrap_entry (wrap_entry),
        .head       (head)
    );

    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign step_end  = (step_reg + CNT_BITS'(1)) == fill_reg;
    assign take      = (taken_reg == '0) || (ltf_reg <= head.start);

    always_comb
    begin
        wrap_entry     = head;
        ctrl.mode      = MODE_HOLD;
        ctrl.new_entry = '{sel: 1'b0, tag: tag, start: start_time, finish: finish_time};

        state_next     = state_reg;
        fill_next      = fill_reg;
        step_next      = step_reg;
        taken_next     = taken_reg;
        emitted_next   = emitted_reg;
        ltf_next       = ltf_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !out_ready;

        tag_next       = tag_reg;
        start_next     = start_reg;
        finish_next    = finish_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (fill_reg < CNT_BITS'(MAX_ACTIVITIES))
                    begin
                        ctrl.mode = MODE_INSERT;
                        fill_next = fill_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        state_next = S_MARK;
                        step_next  = '0;
                    end
                end
            end
            S_MARK:
            begin
                ctrl.mode      = MODE_ROTATE;
                wrap_entry.sel = take;
                if (take)
                begin
                    ltf_next   = head.finish;
                    taken_next = taken_reg + CNT_BITS'(1);
                end
                if (step_end)
                begin
                    state_next = S_EMIT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + CNT_BITS'(1);
                end
            end
            S_EMIT:
            begin
                if (!head.sel || slot_free)
                begin
                    ctrl.mode = MODE_ROTATE;
                    if (head.sel)
                    begin
                        out_valid_next = 1'b1;
                        tag_next       = head.tag;
                        start_next     = head.start;
                        finish_next    = head.finish;
                        last_next      = (emitted_reg + CNT_BITS'(1)) == taken_reg;
                        count_next     = taken_reg;
                        ovf_next       = dropped_reg;
                        emitted_next   = emitted_reg + CNT_BITS'(1);
                    end
                    if (step_end)
                    begin
                        state_next   = S_LOAD;
                        step_next    = '0;
                        fill_next    = '0;
                        dropped_next = 1'b0;
                        taken_next   = '0;
                        emitted_next = '0;
                    end
                    else
                    begin
                        step_next = step_reg + CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            step_reg      <= '0;
            taken_reg     <= '0;
            emitted_reg   <= '0;
            ltf_reg       <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            taken_reg     <= taken_next;
            emitted_reg   <= emitted_next;
            ltf_reg       <= ltf_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= tag_next;
        start_reg  <= start_next;
        finish_reg <= finish_next;
        last_reg   <= last_next;
        count_reg  <= count_next;
        ovf_reg    <= ovf_next;
    end

    assign out_valid       = out_valid_reg;
    assign tag_res         = tag_reg;
    assign start_time_res  = start_reg;
    assign finish_time_res = finish_reg;
    assign last_result     = last_reg;
    assign selected_count  = count_reg;
    assign overflow        = ovf_reg;

endmodule

`default_nettype wire

// ===== design/iasel_cell.sv =====
// ----------------------------------------------------------------------------
// iasel_cell
// One cell of the sorting chain: holds one activity, inserts in finish order
// and rotates toward the head of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module iasel_cell (
    input  wire logic                clk,
    input  wire iasel_pkg::cell_ctrl_t ctrl,
    input  wire logic                active,
    input  wire logic                is_end,
    input  wire iasel_pkg::entry_t   left_entry,
    input  wire logic                left_shift,
    input  wire iasel_pkg::entry_t   right_entry,
    input  wire iasel_pkg::entry_t   wrap_entry,
    output iasel_pkg::entry_t        entry,
    output logic                     shift
);
    import iasel_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // empty cells count as later than any finish time
    assign shift = !active || (entry_reg.finish > ctrl.new_entry.finish);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.mode)
            MODE_INSERT:
            begin
                if (shift)
                begin
                    entry_next = left_shift ? left_entry : ctrl.new_entry;
                end
            end
            MODE_ROTATE:
            begin
                entry_next = is_end ? wrap_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== design/iasel_chain.sv =====
// ----------------------------------------------------------------------------
// iasel_chain
// Row of sorting cells; the head cell feeds the selection scan and the
// scanned item wraps back to the end of the filled part.
// ----------------------------------------------------------------------------
`default_nettype none

module iasel_chain (
    input  wire logic                       clk,
    input  wire iasel_pkg::cell_ctrl_t      ctrl,
    input  wire logic [iasel_pkg::CNT_BITS-1:0] fill,
    input  wire iasel_pkg::entry_t          wrap_entry,
    output iasel_pkg::entry_t               head
);
    import iasel_pkg::*;

    entry_t cell_entry [MAX_ACTIVITIES];
    logic   cell_shift [MAX_ACTIVITIES];

    genvar i;
    generate
        for (i = 0; i < MAX_ACTIVITIES; i++)
        begin : g_cell
            entry_t left_e;
            logic   left_s;
            entry_t right_e;
            logic   act;
            logic   is_end;

            if (i == 0)
            begin : g_first
                assign left_e = ctrl.new_entry;
                assign left_s = 1'b0;
            end
            else
            begin : g_rest
                assign left_e = cell_entry[i-1];
                assign left_s = cell_shift[i-1];
            end

            if (i == MAX_ACTIVITIES - 1)
            begin : g_last
                assign right_e = wrap_entry;
            end
            else
            begin : g_mid
                assign right_e = cell_entry[i+1];
            end

            assign act    = fill > CNT_BITS'(i);
            assign is_end = fill == CNT_BITS'(i + 1);

            iasel_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .active      (act),
                .is_end      (is_end),
                .left_entry  (left_e),
                .left_shift  (left_s),
                .right_entry (right_e),
                .wrap_entry  (wrap_entry),
                .entry       (cell_entry[i]),
                .shift       (cell_shift[i])
            );
        end
    endgenerate

    assign head = cell_entry[0];

endmodule

`default_nettype wire

// ===== test/interval_activity_selector_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_activity_selector_core_tb
// Loads activity sets into the selector and checks every emitted selection,
// in order and field by field, against a greedy earliest-finish predictor.
// A short table covers corner times, ties and reversed arrival; random sets
// follow, including full and overflowing stores, under changing idle rates.
// ----------------------------------------------------------------------------
module interval_activity_selector_core_tb;
    import iasel_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 410;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] finish;
    } held_rec_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] finish;
        logic                 last;
        logic [CNT_BITS-1:0]  count;
        logic                 ovf;
    } pick_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] finish;
        logic                 last;
        logic                 typed;
        pick_t                want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] finish_time;
    logic                 last_item;
    logic                 out_valid;
    logic                 out_ready;
    logic [TAG_BITS-1:0]  tag_res;
    logic [TIME_BITS-1:0] start_time_res;
    logic [TIME_BITS-1:0] finish_time_res;
    logic                 last_result;
    logic [CNT_BITS-1:0]  selected_count;
    logic                 overflow;

    held_rec_t   held_activities [MAX_ACTIVITIES];
    int unsigned held_count;
    logic        dropped_seen;
    logic [TIME_BITS-1:0] prev_taken_finish;
    pick_t       fresh_picks [$];
    pick_t       expected_picks [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    logic [TIME_BITS-1:0] window_base;
    logic [TIME_BITS-1:0] recent_finish;

    plan_row_t plan_rows [20] = '{
        '{8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, '{8'h00, 16'h0000, 16'h0000, 1'b1, 7'd1, 1'b0}},
        '{8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 7'd1, 1'b0}},
        '{8'h5A, 16'hFFFF, 16'h0000, 1'b1, 1'b1, '{8'h5A, 16'hFFFF, 16'h0000, 1'b1, 7'd1, 1'b0}},
        '{8'hA5, 16'h0001, 16'hFFFE, 1'b1, 1'b1, '{8'hA5, 16'h0001, 16'hFFFE, 1'b1, 7'd1, 1'b0}},
        '{8'h11, 16'h0010, 16'h0030, 1'b0, 1'b0, '0},
        '{8'h12, 16'h0000, 16'h0020, 1'b0, 1'b0, '0},
        '{8'h13, 16'h0020, 16'h0030, 1'b0, 1'b0, '0},
        '{8'h14, 16'h0030, 16'h0040, 1'b0, 1'b0, '0},
        '{8'h15, 16'h0025, 16'h0040, 1'b1, 1'b0, '0},
        '{8'h21, 16'h0005, 16'h0009, 1'b0, 1'b0, '0},
        '{8'h22, 16'h0005, 16'h0009, 1'b0, 1'b0, '0},
        '{8'h23, 16'h0005, 16'h0009, 1'b1, 1'b0, '0},
        '{8'h31, 16'h0300, 16'h0400, 1'b0, 1'b0, '0},
        '{8'h32, 16'h0200, 16'h0300, 1'b0, 1'b0, '0},
        '{8'h33, 16'h0100, 16'h0200, 1'b0, 1'b0, '0},
        '{8'h34, 16'h0000, 16'h0100, 1'b1, 1'b0, '0},
        '{8'h41, 16'h0050, 16'h0050, 1'b0, 1'b0, '0},
        '{8'h42, 16'h0060, 16'h0010, 1'b0, 1'b0, '0},
        '{8'h43, 16'h0050, 16'h0060, 1'b0, 1'b0, '0},
        '{8'h44, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0}
    };

    interval_activity_selector_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .tag             (tag),
        .start_time      (start_time),
        .finish_time     (finish_time),
        .last_item       (last_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tag_res         (tag_res),
        .start_time_res  (start_time_res),
        .finish_time_res (finish_time_res),
        .last_result     (last_result),
        .selected_count  (selected_count),
        .overflow        (overflow)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // stable earliest-finish ordering, then greedy take
    function automatic void predict_selection(input logic [TAG_BITS-1:0] t,
                                              input logic [TIME_BITS-1:0] s,
                                              input logic [TIME_BITS-1:0] f,
                                              input logic close);
        int unsigned order [MAX_ACTIVITIES];
        int unsigned n;
        int unsigned k;
        int unsigned taken;
        held_rec_t   a;
        pick_t       p;
        fresh_picks.delete();
        if (held_count < MAX_ACTIVITIES)
        begin
            held_activities[held_count] = '{t, s, f};
            held_count++;
        end
        else
            dropped_seen = 1'b1;
        if (!close)
            return;
        n = held_count;
        for (int unsigned i = 0; i < n; i++)
        begin
            k = i;
            while (k > 0 && held_activities[order[k-1]].finish > held_activities[i].finish)
            begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
        end
        taken = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            a = held_activities[order[i]];
            if (taken == 0 || prev_taken_finish <= a.start)
            begin
                p = '{a.tag, a.start, a.finish, 1'b0, '0, 1'b0};
                fresh_picks.push_back(p);
                prev_taken_finish = a.finish;
                taken++;
            end
        end
        for (int unsigned i = 0; i < taken; i++)
        begin
            fresh_picks[i].last  = (i + 1 == taken);
            fresh_picks[i].count = CNT_BITS'(taken);
            fresh_picks[i].ovf   = dropped_seen;
        end
        held_count   = 0;
        dropped_seen = 1'b0;
    endfunction

    function automatic void draw_interval(output logic [TIME_BITS-1:0] s,
                                          output logic [TIME_BITS-1:0] f);
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 60)
        begin
            s = TIME_BITS'(window_base + $urandom_range(0, 400));
            f = TIME_BITS'(s + $urandom_range(1, 150));
        end
        else if (mode < 80)
        begin
            s = TIME_BITS'($urandom);
            f = TIME_BITS'($urandom);
        end
        else
        begin
            f = recent_finish;
            s = TIME_BITS'(f - $urandom_range(0, 100));
        end
        recent_finish = f;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic offer_activity(input logic [TAG_BITS-1:0] t,
                                  input logic [TIME_BITS-1:0] s,
                                  input logic [TIME_BITS-1:0] f,
                                  input logic close,
                                  input logic typed,
                                  input pick_t typed_pick);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        tag         <= t;
        start_time  <= s;
        finish_time <= f;
        last_item   <= close;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_selection(t, s, f, close);
        if (typed)
            expected_picks.push_back(typed_pick);
        else
            foreach (fresh_picks[i])
                expected_picks.push_back(fresh_picks[i]);
        items_sent++;
        if (items_sent == 137)
        begin
            send_idle_pct = 84;
            recv_idle_pct = 29;
        end
        else if (items_sent == 274)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pick_t want;
        if (out_valid && out_ready)
        begin
            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected item, tag %0h", $time, tag_res);
                mismatch_count++;
            end
            else
            begin
                want = expected_picks.pop_front();
                check_field("tag_res", want.tag, tag_res);
                check_field("start_time_res", want.start, start_time_res);
                check_field("finish_time_res", want.finish, finish_time_res);
                check_field("last_result", want.last, last_result);
                check_field("selected_count", want.count, selected_count);
                check_field("overflow", want.ovf, overflow);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("interval_activity_selector_core: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned set_no;
        int unsigned set_size;
        logic [TIME_BITS-1:0] s;
        logic [TIME_BITS-1:0] f;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        tag               <= '0;
        start_time        <= '0;
        finish_time       <= '0;
        last_item         <= 1'b0;
        out_ready         <= 1'b0;
        cycle_count       = 0;
        mismatch_count    = 0;
        items_sent        = 0;
        held_count        = 0;
        dropped_seen      = 1'b0;
        prev_taken_finish = '0;
        recent_finish     = '0;
        window_base       = '0;
        send_idle_pct     = 29;
        recv_idle_pct     = 84;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i])
            offer_activity(plan_rows[i].tag, plan_rows[i].start, plan_rows[i].finish,
                           plan_rows[i].last, plan_rows[i].typed, plan_rows[i].want);

        set_no = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (set_no == 2)
                set_size = MAX_ACTIVITIES;
            else if (set_no == 9)
                set_size = MAX_ACTIVITIES + 2;
            else if (set_no == 30)
                set_size = $urandom_range(MAX_ACTIVITIES + 1, MAX_ACTIVITIES + 6);
            else if ($urandom_range(0, 9) == 0)
                set_size = $urandom_range(9, 20);
            else
                set_size = $urandom_range(1, 8);
            window_base = TIME_BITS'($urandom);
            for (int unsigned k = 0; k < set_size; k++)
            begin
                // full store of disjoint intervals in reverse arrival order
                if (set_size == MAX_ACTIVITIES)
                begin
                    s = TIME_BITS'((MAX_ACTIVITIES - 1 - k) * 1000 + $urandom_range(0, 50));
                    f = TIME_BITS'(s + $urandom_range(1, 900));
                end
                else
                    draw_interval(s, f);
                offer_activity(TAG_BITS'($urandom), s, f, k + 1 == set_size, 1'b0, '0);
            end
            set_no++;
        end
        in_valid <= 1'b0;

        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (3 * MAX_ACTIVITIES + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("interval_activity_selector_core: match");
        else
            $display("interval_activity_selector_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/iasel_pkg.sv
design/iasel_cell.sv
design/iasel_chain.sv
design/interval_activity_selector_core.sv
test/interval_activity_selector_core_tb.sv
